// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the hash core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SLH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SLH_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/slh_pkg.sv =====
// Types, constants and round functions of the salted lookup3 word hash.
package slh_pkg;

    localparam logic [31:0] HASH_SEED = 32'hdeadbeef;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_MIX   = 2'd1;
    localparam logic [1:0] OP_FINAL = 2'd2;
    localparam logic [1:0] OP_EMPTY = 2'd3;

    localparam logic [1:0] LANE_A = 2'd0;
    localparam logic [1:0] LANE_B = 2'd1;
    localparam logic [1:0] LANE_C = 2'd2;

    typedef logic [2:0][31:0] lanes_t;

    typedef struct packed {
        logic [31:0] word;
        logic        load_init;
        logic [31:0] init_val;
        logic [1:0]  lane;
        logic [1:0]  op;
    } entry_t;

    localparam int MIX_ROT [6] = '{4, 6, 8, 16, 19, 4};
    localparam int MIX_TGT [6] = '{0, 1, 2, 0, 1, 2};
    localparam int MIX_SRC [6] = '{2, 0, 1, 2, 0, 1};
    localparam int MIX_ADD [6] = '{1, 2, 0, 1, 2, 0};

    localparam int FIN_ROT [7] = '{14, 11, 25, 16, 4, 14, 24};
    localparam int FIN_TGT [7] = '{2, 0, 1, 2, 0, 1, 2};
    localparam int FIN_SRC [7] = '{1, 2, 0, 1, 2, 0, 1};

    function automatic logic [31:0] rotl(logic [31:0] x, int r);
        logic [63:0] d;
        d = {x, x} << r;
        return d[63:32];
    endfunction

    function automatic lanes_t mix_step(lanes_t l, int k);
        lanes_t r;
        r = l;
        r[MIX_TGT[k]] = (r[MIX_TGT[k]] - r[MIX_SRC[k]]) ^ rotl(r[MIX_SRC[k]], MIX_ROT[k]);
        r[MIX_SRC[k]] = r[MIX_SRC[k]] + r[MIX_ADD[k]];
        return r;
    endfunction

    function automatic lanes_t final_step(lanes_t l, int k);
        lanes_t r;
        r = l;
        r[FIN_TGT[k]] = (r[FIN_TGT[k]] ^ r[FIN_SRC[k]]) - rotl(r[FIN_SRC[k]], FIN_ROT[k]);
        return r;
    endfunction

endpackage

// ===== rtl/core/slh_front.sv =====
// Front end: tracks message position and classifies each accepted word.
module slh_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [31:0]     data_word,
    input  logic [31:0]     salt_word,
    input  logic [29:0]     message_words,
    output slh_pkg::entry_t entry
);
    import slh_pkg::*;

    logic [29:0] words_left_reg, words_left_next;
    logic [1:0]  slot_reg, slot_next;
    logic        first;
    logic [29:0] wl_cur, wl_after;

    always_comb
    begin
        first           = (words_left_reg == 30'd0);
        wl_cur          = first ? message_words : words_left_reg;
        wl_after        = wl_cur - 30'd1;
        entry.word      = data_word ^ salt_word;
        entry.load_init = first;
        entry.init_val  = HASH_SEED + {message_words, 2'b00};
        entry.lane      = first ? LANE_A : slot_reg;
        words_left_next = words_left_reg;
        slot_next       = slot_reg;
        if (first && message_words == 30'd0)
        begin
            entry.op = OP_EMPTY;
        end
        else if (wl_after == 30'd0)
        begin
            entry.op = OP_FINAL;
        end
        else if (entry.lane == LANE_C)
        begin
            entry.op = OP_MIX;
        end
        else
        begin
            entry.op = OP_NONE;
        end
        if (accept)
        begin
            unique case (entry.op) inside
                OP_EMPTY:
                begin
                    words_left_next = 30'd0;
                    slot_next       = LANE_A;
                end
                OP_FINAL, OP_MIX:
                begin
                    words_left_next = wl_after;
                    slot_next       = LANE_A;
                end
                default:
                begin
                    words_left_next = wl_after;
                    slot_next       = entry.lane + 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_left_reg <= 30'd0;
            slot_reg       <= 2'd0;
        end
        else
        begin
            words_left_reg <= words_left_next;
            slot_reg       <= slot_next;
        end
    end

endmodule

// ===== rtl/core/slh_queue.sv =====
// Short queue of classified words between front and back ends.
`include "assert_macros.svh"

module slh_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            enq,
    input  slh_pkg::entry_t enq_entry,
    input  logic            deq,
    output slh_pkg::entry_t head,
    output logic            q_full,
    output logic            q_empty
);
    import slh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]   head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0]   tail_ptr_reg, tail_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        q_full        = (count_reg == CNT_W'(DEPTH));
        q_empty       = (count_reg == '0);
        head          = slots_reg[head_ptr_reg];
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        if (deq)
        begin
            head_ptr_next = (head_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : head_ptr_reg + PTR_W'(1);
        end
        if (enq)
        begin
            tail_ptr_next = (tail_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : tail_ptr_reg + PTR_W'(1);
        end
        case ({enq, deq})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slots_reg[tail_ptr_reg] <= enq_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            count_reg    <= count_next;
        end
    end

    `SLH_NEVER(a_count_range, count_reg > CNT_W'(DEPTH), "queue count above depth")
    `SLH_NEVER(a_deq_empty, deq && (count_reg == '0), "dequeue from empty queue")
    `SLH_NEVER(a_full_empty, q_full && q_empty, "queue full and empty at once")

endmodule

// ===== rtl/core/slh_back.sv =====
// Back end: lane adds, mix and final scramble, result register.
`include "assert_macros.svh"

module slh_back (
    input  logic            clk,
    input  logic            rst_n,
    input  slh_pkg::entry_t head,
    input  logic            head_valid,
    output logic            deq,
    input  logic            pop,
    output logic            empty,
    output logic [63:0]     hash_value
);
    import slh_pkg::*;

    localparam logic [2:0] ST_RUN  = 3'd0;
    localparam logic [2:0] ST_MIX0 = 3'd1;
    localparam logic [2:0] ST_MIX1 = 3'd2;
    localparam logic [2:0] ST_FIN0 = 3'd3;
    localparam logic [2:0] ST_FIN1 = 3'd4;

    logic [2:0]  state_reg, state_next;
    lanes_t      lanes_reg, lanes_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] hash_reg, hash_next;
    logic        out_free, res_load;
    lanes_t      added, mix0, mix1, fin0, fin1;

    always_comb
    begin
        out_free = !out_valid_reg || pop;

        added = head.load_init ? {3{head.init_val}} : lanes_reg;
        case (head.lane)
            LANE_A:  added[0] = added[0] + head.word;
            LANE_B:  added[1] = added[1] + head.word;
            default: added[2] = added[2] + head.word;
        endcase

        mix0 = lanes_reg;
        for (int k = 0; k < 3; k++)
        begin
            mix0 = mix_step(mix0, k);
        end
        mix1 = lanes_reg;
        for (int k = 3; k < 6; k++)
        begin
            mix1 = mix_step(mix1, k);
        end
        fin0 = lanes_reg;
        for (int k = 0; k < 4; k++)
        begin
            fin0 = final_step(fin0, k);
        end
        fin1 = lanes_reg;
        for (int k = 4; k < 7; k++)
        begin
            fin1 = final_step(fin1, k);
        end

        deq        = 1'b0;
        res_load   = 1'b0;
        hash_next  = hash_reg;
        state_next = state_reg;
        lanes_next = lanes_reg;

        unique case (state_reg)
            ST_RUN:
            begin
                if (head_valid && (head.op != OP_EMPTY || out_free))
                begin
                    deq = 1'b1;
                    case (head.op)
                        OP_EMPTY:
                        begin
                            lanes_next = {3{head.init_val}};
                            res_load   = 1'b1;
                            hash_next  = {head.init_val, head.init_val};
                        end
                        OP_MIX:
                        begin
                            lanes_next = added;
                            state_next = ST_MIX0;
                        end
                        OP_FINAL:
                        begin
                            lanes_next = added;
                            state_next = ST_FIN0;
                        end
                        default:
                        begin
                            lanes_next = added;
                        end
                    endcase
                end
            end
            ST_MIX0:
            begin
                lanes_next = mix0;
                state_next = ST_MIX1;
            end
            ST_MIX1:
            begin
                lanes_next = mix1;
                state_next = ST_RUN;
            end
            ST_FIN0:
            begin
                lanes_next = fin0;
                state_next = ST_FIN1;
            end
            ST_FIN1:
            begin
                if (out_free)
                begin
                    lanes_next = fin1;
                    res_load   = 1'b1;
                    hash_next  = {fin1[1], fin1[2]};
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        empty      = !out_valid_reg;
        hash_value = hash_reg;
    end

    always_ff @(posedge clk)
    begin
        lanes_reg <= lanes_next;
        hash_reg  <= hash_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `SLH_ASSERT(a_load_free, res_load |-> (!out_valid_reg || pop), "result overwrites pending")
    `SLH_ASSERT(a_mix_seq, (state_reg == ST_MIX0) |=> (state_reg == ST_MIX1), "mix phase skipped")
    `SLH_NEVER(a_deq_busy, deq && (state_reg != ST_RUN), "dequeue during mix or final")

endmodule

// ===== rtl/core/salted_lookup3_word_hash.sv =====
// Top level of the salted lookup3 word hash.
//
//  channel | handshake          | fields
//  --------+--------------------+-----------------------------------------
//  input   | push / full        | data_word, salt_word, message_words
//  result  | empty / pop        | hash_value
//
// Words enter the queue at one per cycle while full is low; the back end takes one per cycle
// in ST_RUN, an empty message's item only while the result register is free. A full group
// that is not the last passes ST_MIX0 and ST_MIX1, taking no word; after the last word, the
// final scramble runs ST_FIN0, then waits in ST_FIN1 for a free result register; the result
// waits there. A zero-length message loads its result at the edge its item leaves the queue.
// Reset clears the queue, message position and result valid; no clearing pass.
module salted_lookup3_word_hash #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] data_word,
    input  logic [31:0] salt_word,
    input  logic [29:0] message_words,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] hash_value
);
    import slh_pkg::*;

    logic   accept;
    logic   q_full, q_empty, deq;
    entry_t enq_entry, head;

    assign full   = q_full;
    assign accept = push && !q_full;

    slh_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_word     (data_word),
        .salt_word     (salt_word),
        .message_words (message_words),
        .entry         (enq_entry)
    );

    slh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq       (accept),
        .enq_entry (enq_entry),
        .deq       (deq),
        .head      (head),
        .q_full    (q_full),
        .q_empty   (q_empty)
    );

    slh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_empty),
        .deq        (deq),
        .pop        (pop),
        .empty      (empty),
        .hash_value (hash_value)
    );

endmodule
